FILE: hdl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd1;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_CLEAR      = 3'd4;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] push_value;
	} dq_req_t;

	typedef struct packed {
		logic [31:0] popped_value;
		logic [1:0]  status;
		logic        now_empty;
		logic        now_full;
	} dq_rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dq_cmd_t;

endpackage

FILE: hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
//   channel   | transfer when       | payload
//   ----------+---------------------+-----------------------------------------
//   request   | start && !busy      | req: req_type, push_value
//   result    | done (one cycle)    | rsp: popped_value, status, now_empty,
//             |                     |      now_full
//
// Each request runs in three steps: the request is captured, then executed
// against the ring store (pointer update, one write or one read), then the
// result is shown for one cycle with done high. The store's read port is
// registered. busy is high from capture to the result cycle, so a new
// request is taken the cycle after done. Reset empties the queue; the store
// itself is not cleared. The receiver cannot stall done.
module double_ended_queue #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  dq_pkg::dq_req_t req,
	output logic            done,
	output dq_pkg::dq_rsp_t rsp
);

	// command bundle from the sequencer to the datapath
	dq_pkg::dq_cmd_t cmd;

	// sequencer: capture, execute, present
	dq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// datapath: ring store, pointers, count and result registers
	dq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

FILE: hdl/dq_ctrl.sv
// Sequencer for one request: capture, execute, present result.
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output dq_pkg::dq_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

endmodule

FILE: hdl/dq_datapath.sv
// Ring store, end pointers, entry count and result registers.
module dq_datapath #(
	parameter int DEPTH      = dq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dq_pkg::dq_cmd_t cmd,
	input  dq_pkg::dq_req_t req,
	output dq_pkg::dq_rsp_t rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	dq_pkg::dq_req_t req_q;
	logic [IW-1:0]   front_q, back_q;
	logic [CW-1:0]   count_q;
	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_q;
	logic            pop_ok_q;
	logic [1:0]      status_q;
	logic            empty_q, full_q;

	logic [IW-1:0]   front_prev, front_next, back_prev, back_next;
	logic [IW-1:0]   front_nxt, back_nxt, wr_addr, rd_addr;
	logic [CW-1:0]   count_nxt;
	logic            ring_empty, is_full, wr_en, pop_ok;
	logic [1:0]      status_nxt;
	logic [63:0]     push_ext, rd_ext;
	logic [DATA_WIDTH-1:0] wr_data;

	assign front_prev = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_next = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? LAST_IDX : back_q - 1'b1;
	assign back_next  = (back_q == LAST_IDX) ? '0 : back_q + 1'b1;
	assign ring_empty = (count_q == '0);
	assign is_full    = (count_q == FULL_CNT);
	assign push_ext   = 64'(req_q.push_value);
	assign wr_data    = push_ext[DATA_WIDTH-1:0];

	always_comb begin
		front_nxt  = front_q;
		back_nxt   = back_q;
		count_nxt  = count_q;
		wr_en      = 1'b0;
		wr_addr    = back_q;
		rd_addr    = front_q;
		pop_ok     = 1'b0;
		status_nxt = dq_pkg::ST_OK;
		unique case (req_q.req_type)
			dq_pkg::REQ_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = dq_pkg::ST_PUSH_FULL;
				end else begin
					front_nxt = front_prev;
					wr_addr   = front_prev;
					wr_en     = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			dq_pkg::REQ_POP_FRONT: begin
				if (ring_empty) begin
					status_nxt = dq_pkg::ST_POP_EMPTY;
				end else begin
					rd_addr   = front_q;
					front_nxt = front_next;
					pop_ok    = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			dq_pkg::REQ_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = dq_pkg::ST_PUSH_FULL;
				end else begin
					wr_addr   = back_q;
					back_nxt  = back_next;
					wr_en     = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
			dq_pkg::REQ_POP_BACK: begin
				if (ring_empty) begin
					status_nxt = dq_pkg::ST_POP_EMPTY;
				end else begin
					rd_addr   = back_prev;
					back_nxt  = back_prev;
					pop_ok    = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			dq_pkg::REQ_CLEAR: begin
				front_nxt = '0;
				back_nxt  = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			count_q  <= '0;
			pop_ok_q <= 1'b0;
			status_q <= dq_pkg::ST_OK;
			empty_q  <= 1'b1;
			full_q   <= 1'b0;
		end else if (cmd.exec) begin
			front_q  <= front_nxt;
			back_q   <= back_nxt;
			count_q  <= count_nxt;
			pop_ok_q <= pop_ok;
			status_q <= status_nxt;
			empty_q  <= (count_nxt == '0);
			full_q   <= (count_nxt == FULL_CNT);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.exec) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_ext           = 64'(rd_q);
	assign rsp.popped_value = pop_ok_q ? rd_ext[31:0] : 32'd0;
	assign rsp.status       = status_q;
	assign rsp.now_empty    = empty_q;
	assign rsp.now_full     = full_q;

endmodule
